/* rtl/sprite_priority_sorter_assert.svh */
// Assertion macros for the sprite priority sorter.
`ifndef SPRITE_PRIORITY_SORTER_ASSERT_SVH
`define SPRITE_PRIORITY_SORTER_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define SPS_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sprite_priority_sorter: same-cycle check failed");

// Check that post holds in the cycle after pre.
`define SPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sprite_priority_sorter: next-cycle check failed");

`endif

/* rtl/sps_pkg.sv */
// Package with constants and types of the sprite priority sorter.
`default_nettype none

package sps_pkg;

  localparam int SPRITE_SLOTS    = 128;
  localparam int PRIORITY_LEVELS = 4;

  localparam int SLOT_W = 7;
  localparam int CNT_W  = 8;
  localparam int LVL_W  = 3;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SPRITE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  SLOT_CNT  = CNT_W'(SPRITE_SLOTS);
  localparam logic [LVL_W-1:0]  LVL_CNT   = LVL_W'(PRIORITY_LEVELS);

  localparam logic [15:0] DISABLED_WORD0 = 16'h0200;

  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] prio;
    logic [9:0] tile;
    logic [1:0] size;
    logic [8:0] x;
    logic [7:0] y;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* rtl/sprite_priority_sorter.sv */
// Top level: sprite list store and priority-ordered slot readout.
// Begin and add transactions: result registered, then moved to the output register when free.
// Read: scans the stored entries level by level from priority 0 upward, one list-memory read
// per entry examined; yields the next entry by priority and list order, else a disabled slot.
// One transaction at a time; the next is taken while the last result waits downstream.
// Synchronous reset empties the list and rewinds the readout; memory contents are not cleared.
`default_nettype none

module sprite_priority_sorter
  import sps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [8:0]  in_pos_x,
  input  wire logic [7:0]  in_pos_y,
  input  wire logic [9:0]  in_tile_number,
  input  wire logic [1:0]  in_shape_size,
  input  wire logic [1:0]  in_draw_priority,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_slot_number,
  output logic             out_slot_enabled,
  output logic [15:0]      out_word_zero,
  output logic [15:0]      out_word_one,
  output logic [15:0]      out_word_two,
  output logic             out_add_accepted
);

`include "sprite_priority_sorter_assert.svh"

  entry_t mem [SPRITE_SLOTS];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [LVL_W-1:0]  scan_lvl_r, scan_lvl_nxt;
  logic [CNT_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  pend_pos_r, pend_pos_nxt;
  logic [LVL_W-1:0]  pend_lvl_r, pend_lvl_nxt;
  entry_t            rd_data_r;

  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_en_r, res_en_nxt;
  logic [15:0]       res_w0_r, res_w0_nxt;
  logic [15:0]       res_w1_r, res_w1_nxt;
  logic [15:0]       res_w2_r, res_w2_nxt;
  logic              res_add_r, res_add_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_en_r;
  logic [15:0]       out_w0_r;
  logic [15:0]       out_w1_r;
  logic [15:0]       out_w2_r;
  logic              out_add_r;
  logic              out_load;

  logic              mem_we;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  entry_t            wr_entry;
  logic              in_fire;
  logic              hit;
  logic              finish;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign wr_entry = '{prio: in_draw_priority, tile: in_tile_number, size: in_shape_size,
                      x: in_pos_x, y: in_pos_y};
  assign hit      = pend_r && ({1'b0, rd_data_r.prio} == pend_lvl_r);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_slot_nxt  = rd_slot_r;
    scan_lvl_nxt = scan_lvl_r;
    scan_pos_nxt = scan_pos_r;
    pend_nxt     = 1'b0;
    pend_pos_nxt = pend_pos_r;
    pend_lvl_nxt = pend_lvl_r;
    res_slot_nxt = res_slot_r;
    res_en_nxt   = res_en_r;
    res_w0_nxt   = res_w0_r;
    res_w1_nxt   = res_w1_r;
    res_w2_nxt   = res_w2_r;
    res_add_nxt  = res_add_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = scan_pos_r[SLOT_W-1:0];
    finish       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_slot_nxt = '0;
          res_en_nxt   = 1'b0;
          res_w0_nxt   = '0;
          res_w1_nxt   = '0;
          res_w2_nxt   = '0;
          res_add_nxt  = 1'b0;
          state_nxt    = ST_DONE;
          unique case (in_mode)
            MODE_BEGIN: begin
              count_nxt    = '0;
              rd_slot_nxt  = '0;
              scan_lvl_nxt = '0;
              scan_pos_nxt = '0;
            end
            MODE_ADD: begin
              if (count_r < SLOT_CNT) begin
                mem_we      = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
                res_add_nxt = 1'b1;
              end
              rd_slot_nxt  = '0;
              scan_lvl_nxt = '0;
              scan_pos_nxt = '0;
            end
            MODE_READ: begin
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          scan_pos_nxt = pend_pos_r + CNT_W'(1);
          scan_lvl_nxt = pend_lvl_r;
          res_en_nxt   = 1'b1;
          res_w0_nxt   = {8'd0, rd_data_r.y};
          res_w1_nxt   = {rd_data_r.size, 5'd0, rd_data_r.x};
          res_w2_nxt   = {4'd0, rd_data_r.prio, rd_data_r.tile};
          finish       = 1'b1;
        end else if (scan_lvl_r >= LVL_CNT) begin
          res_en_nxt = 1'b0;
          res_w0_nxt = DISABLED_WORD0;
          res_w1_nxt = '0;
          res_w2_nxt = '0;
          finish     = 1'b1;
        end else if (scan_pos_r < count_r) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_pos_nxt = scan_pos_r;
          pend_lvl_nxt = scan_lvl_r;
          scan_pos_nxt = scan_pos_r + CNT_W'(1);
        end else begin
          scan_lvl_nxt = scan_lvl_r + LVL_W'(1);
          scan_pos_nxt = '0;
        end
        if (finish) begin
          res_slot_nxt = rd_slot_r;
          res_add_nxt  = 1'b0;
          state_nxt    = ST_DONE;
          if (rd_slot_r == SLOT_LAST) begin
            rd_slot_nxt  = '0;
            scan_lvl_nxt = '0;
            scan_pos_nxt = '0;
          end else begin
            rd_slot_nxt = rd_slot_r + SLOT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[SLOT_W-1:0]] <= wr_entry;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_slot_r   <= '0;
      scan_lvl_r  <= '0;
      scan_pos_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_slot_r   <= rd_slot_nxt;
      scan_lvl_r  <= scan_lvl_nxt;
      scan_pos_r  <= scan_pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_pos_r <= pend_pos_nxt;
    pend_lvl_r <= pend_lvl_nxt;
    res_slot_r <= res_slot_nxt;
    res_en_r   <= res_en_nxt;
    res_w0_r   <= res_w0_nxt;
    res_w1_r   <= res_w1_nxt;
    res_w2_r   <= res_w2_nxt;
    res_add_r  <= res_add_nxt;
    if (out_load) begin
      out_slot_r <= res_slot_r;
      out_en_r   <= res_en_r;
      out_w0_r   <= res_w0_r;
      out_w1_r   <= res_w1_r;
      out_w2_r   <= res_w2_r;
      out_add_r  <= res_add_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_number  = out_slot_r;
  assign out_slot_enabled = out_en_r;
  assign out_word_zero    = out_w0_r;
  assign out_word_one     = out_w1_r;
  assign out_word_two     = out_w2_r;
  assign out_add_accepted = out_add_r;

  `SPS_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE)
  `SPS_ASSERT_SAME(a_count_bounded, 1'b1, count_r <= SLOT_CNT)
  `SPS_ASSERT_SAME(a_level_bounded, 1'b1, scan_lvl_r <= LVL_CNT)
  `SPS_ASSERT_SAME(a_pend_in_scan, pend_r, state_r == ST_SCAN)
  `SPS_ASSERT_NEXT(a_done_loads_out, out_load, out_valid_r && state_r == ST_IDLE)

endmodule

`default_nettype wire
